### rtl/pef_pkg.sv
// ---------------------------------------------------------------------------
// pef_pkg
// Shared constants, register codes and beat control type for the peak
// envelope follower.
// ---------------------------------------------------------------------------
package pef_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int HOLD_BITS          = 20;
    localparam int CFG_INDEX_BITS     = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ATTACK_COEF   = 2'd0,
        REG_RELEASE_COEF  = 2'd1,
        REG_RELEASE_LEVEL = 2'd2,
        REG_HOLD_SAMPLES  = 2'd3
    } cfg_reg_t;

    // control travelling with a beat between stages
    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctl_t;

    // widest configuration register
    function automatic int cfg_data_bits(input int sample_bits, input int coef_frac_bits);
        int w;
        w = sample_bits;
        if (coef_frac_bits + 1 > w)
        begin
            w = coef_frac_bits + 1;
        end
        if (HOLD_BITS > w)
        begin
            w = HOLD_BITS;
        end
        return w;
    endfunction

endpackage

### rtl/pef_in_stage.sv
// ---------------------------------------------------------------------------
// pef_in_stage
// Input register for the sample stream and magnitude of the held sample.
// ---------------------------------------------------------------------------
module pef_in_stage
    import pef_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   s_tlast,
    input  logic                   advance,
    output beat_ctl_t              ctl,
    output logic [SAMPLE_BITS-1:0] mag
);

    beat_ctl_t              ctl_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    assign s_tready = !ctl_reg.valid || advance;
    assign ctl      = ctl_reg;

    // most negative sample maps to 2^(N-1), which fits unsigned
    assign mag = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (s_tvalid && s_tready)
        begin
            ctl_reg.valid <= 1'b1;
            ctl_reg.last  <= s_tlast;
        end
        else if (advance)
        begin
            ctl_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= sample;
        end
    end

endmodule

### rtl/pef_env_core.sv
// ---------------------------------------------------------------------------
// pef_env_core
// Configuration registers, envelope / peak / hold state and the
// attack-release-hold update.
// ---------------------------------------------------------------------------
module pef_env_core
    import pef_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cfg_data_bits(SAMPLE_BITS, COEF_FRAC_BITS)-1:0] cfg_wdata,
    input  logic                      advance,
    input  logic [SAMPLE_BITS-1:0]    mag,
    output logic [SAMPLE_BITS-1:0]    env_next
);

    localparam int COEF_W = COEF_FRAC_BITS + 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = COEF_W + 1 + DIFF_W;
    localparam int SUM_W  = SAMPLE_BITS + 2;

    localparam logic [COEF_W-1:0]      COEF_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] ENV_TOP  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [COEF_W-1:0]      attack_coef_reg;
    logic [COEF_W-1:0]      release_coef_reg;
    logic [SAMPLE_BITS-1:0] release_level_reg;
    logic [HOLD_BITS-1:0]   hold_samples_reg;

    logic [SAMPLE_BITS-1:0] env_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [HOLD_BITS-1:0]   hold_reg;

    logic signed [DIFF_W-1:0] diff;
    logic                     falling;
    logic                     holding;
    logic [COEF_W-1:0]        att_c;
    logic [COEF_W-1:0]        rel_c;
    logic [COEF_W-1:0]        coef_sel;
    logic signed [COEF_W:0]   coef_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step_full;
    logic signed [DIFF_W-1:0] step;
    logic signed [SUM_W-1:0]  sum;
    logic [SAMPLE_BITS-1:0]   sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coef_reg   <= COEF_ONE;
            release_coef_reg  <= COEF_ONE;
            release_level_reg <= '0;
            hold_samples_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ATTACK_COEF:   attack_coef_reg   <= cfg_wdata[COEF_W-1:0];
                REG_RELEASE_COEF:  release_coef_reg  <= cfg_wdata[COEF_W-1:0];
                REG_RELEASE_LEVEL: release_level_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_HOLD_SAMPLES:  hold_samples_reg  <= cfg_wdata[HOLD_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        diff     = $signed({1'b0, mag}) - $signed({1'b0, env_reg});
        falling  = diff[DIFF_W-1];
        holding  = falling && (hold_reg != '0);
        att_c    = (attack_coef_reg > COEF_ONE) ? COEF_ONE : attack_coef_reg;
        rel_c    = (release_coef_reg > COEF_ONE) ? COEF_ONE : release_coef_reg;
        coef_sel = (falling && (env_reg > release_level_reg)) ? rel_c : att_c;
        coef_s   = $signed({1'b0, coef_sel});
        prod     = coef_s * diff;
        // arithmetic shift floors toward minus infinity; |step| <= |diff|
        step_full = prod >>> COEF_FRAC_BITS;
        step      = step_full[DIFF_W-1:0];
        sum       = $signed({2'b00, env_reg}) + SUM_W'(step);
        if (sum[SUM_W-1])
        begin
            sat = '0;
        end
        else if (sum > $signed({2'b00, ENV_TOP}))
        begin
            sat = ENV_TOP;
        end
        else
        begin
            sat = sum[SAMPLE_BITS-1:0];
        end
        env_next = holding ? env_reg : sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg  <= '0;
            peak_reg <= '0;
            hold_reg <= '0;
        end
        else if (advance)
        begin
            if (falling)
            begin
                if (holding)
                begin
                    hold_reg <= hold_reg - 1'b1;
                end
                else
                begin
                    env_reg  <= sat;
                    peak_reg <= sat;
                end
            end
            else
            begin
                env_reg <= sat;
                if (sat >= peak_reg)
                begin
                    peak_reg <= sat;
                    hold_reg <= hold_samples_reg;
                end
            end
        end
    end

endmodule

### rtl/pef_out_stage.sv
// ---------------------------------------------------------------------------
// pef_out_stage
// Result register driving the envelope stream.
// ---------------------------------------------------------------------------
module pef_out_stage
    import pef_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  beat_ctl_t              ld_ctl,
    input  logic [SAMPLE_BITS-1:0] env_in,
    output logic                   load_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_BITS-1:0] envelope,
    output logic                   m_tlast
);

    logic                   valid_reg;
    logic                   last_reg;
    logic [SAMPLE_BITS-1:0] env_reg;

    assign load_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign envelope   = env_reg;
    assign m_tlast    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= ld_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_ctl.valid && load_ready)
        begin
            env_reg  <= env_in;
            last_reg <= ld_ctl.last;
        end
    end

endmodule

### rtl/peak_envelope_follower_hold.sv
// ---------------------------------------------------------------------------
// peak_envelope_follower_hold
// Peak envelope follower with attack, release and hold, one envelope value
// per audio sample.
// ---------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tdata: sample, tlast: last_in_block
//  m_*       out        m_tvalid/m_tready   tdata: envelope, tlast: last_out
//  cfg_*     in         cfg_wen             cfg_index, cfg_wdata
//
//  One beat per clock sustained while m_tready is high; each input beat
//  passes the input register, then the update into the result register.
//  Rate is set by the envelope feedback loop: subtract, multiply, add and
//  saturate, all combinational.
//  Reset clears the envelope, peak and hold count and sets both
//  coefficients to 1.0. A stalled m_tready holds the result and backs up
//  into s_tready without losing beats.
// ---------------------------------------------------------------------------
module peak_envelope_follower_hold
    import pef_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,   // [SAMPLE_BITS-1:0] envelope
    output logic                      m_tlast,
    input  logic                      cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cfg_data_bits(SAMPLE_BITS, COEF_FRAC_BITS)-1:0] cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam logic [SAMPLE_BITS-1:0] ENV_TOP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    beat_ctl_t              in_ctl;
    beat_ctl_t              ld_ctl;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] env_next;
    logic [SAMPLE_BITS-1:0] envelope;
    logic                   load_ready;
    logic                   advance;

    assign advance = in_ctl.valid && load_ready;
    assign ld_ctl  = '{valid: advance, last: in_ctl.last};
    assign m_tdata = TDATA_W'(envelope);

    pef_in_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sample   (s_tdata[SAMPLE_BITS-1:0]),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .ctl      (in_ctl),
        .mag      (mag)
    );

    pef_env_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .mag       (mag),
        .env_next  (env_next)
    );

    pef_out_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .ld_ctl     (ld_ctl),
        .env_in     (env_next),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .envelope   (envelope),
        .m_tlast    (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // an update always produces a result beat next cycle
    a_advance_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("update did not produce a result beat");

    // a taken result with no update behind it empties the result register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !advance) |=> !m_tvalid)
        else $error("result beat repeated");

    // envelope stays within saturation range
    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (envelope <= ENV_TOP))
        else $error("envelope out of range");

    // input register cannot be overwritten while its beat is unused
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ctl.valid && !load_ready) |-> !s_tready)
        else $error("input register overrun");
`endif

endmodule

### sim/peak_envelope_follower_hold_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// peak_envelope_follower_hold_tb
// Self-checking bench for the peak envelope follower. A short directed table
// hits the sample extremes, coefficient clamping, hold countdown and release
// switching. It is followed by bursty random audio under several register
// settings and three handshake pressure mixes. Envelope beats are compared
// with an in-bench envelope tracker, or with the table value for typed rows.
// ---------------------------------------------------------------------------
module peak_envelope_follower_hold_tb
    import pef_pkg::*;
();

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int CF = COEF_FRAC_BITS_DEF;
    localparam int TW = ((SB + 7) / 8) * 8;
    localparam int CW = cfg_data_bits(SB, CF);
    localparam longint COEF_ONE = longint'(1) << CF;
    localparam longint ENV_TOP  = longint'(1) << (SB - 1);

    typedef struct {
        logic [SB-1:0] envelope;
        logic          last;
    } env_beat_t;

    typedef struct {
        bit            is_cfg;
        cfg_reg_t      reg_idx;
        logic [CW-1:0] value;
        logic [SB-1:0] smp;
        bit            last;
        bit            typed;
        logic [SB-1:0] env;
    } step_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [TW-1:0]             s_tdata = '0;      // [SB-1:0] sample
    logic                      s_tlast = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [TW-1:0]             m_tdata;           // [SB-1:0] envelope
    logic                      m_tlast;
    logic                      cfg_wen = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CW-1:0]             cfg_wdata = '0;

    // typed expectation travels with the beat being driven
    logic                      drv_typed = 1'b0;
    logic [SB-1:0]             drv_env = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int err_count   = 0;
    int sent_count  = 0;
    int recv_count  = 0;
    int wr_count    = 0;

    env_beat_t env_exp_q[$];
    step_row_t directed_q[$];

    // tracker state and its copy of the registers
    logic [SB-1:0]        env_q = '0;
    logic [SB-1:0]        peak_q = '0;
    logic [HOLD_BITS-1:0] hold_q = '0;
    logic [CF:0]          attack_r = COEF_ONE[CF:0];
    logic [CF:0]          release_r = COEF_ONE[CF:0];
    logic [SB-1:0]        rlevel_r = '0;
    logic [HOLD_BITS-1:0] hold_r = '0;

    peak_envelope_follower_hold i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic longint coef_clamped(input logic [CF:0] c);
        return (longint'(c) > COEF_ONE) ? COEF_ONE : longint'(c);
    endfunction

    function automatic logic [SB-1:0] env_saturate(input longint v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > ENV_TOP)
        begin
            return ENV_TOP[SB-1:0];
        end
        return v[SB-1:0];
    endfunction

    // advance the tracker by one sample, return the new envelope
    function automatic logic [SB-1:0] track_envelope(input logic [SB-1:0] smp);
        longint mag;
        longint diff;
        longint coef;
        mag  = smp[SB-1] ? (longint'(1) << SB) - longint'(smp) : longint'(smp);
        diff = mag - longint'(env_q);
        if (diff < 0)
        begin
            if (hold_q != 0)
            begin
                hold_q = hold_q - 1'b1;
            end
            else
            begin
                coef   = (env_q > rlevel_r) ? coef_clamped(release_r) : coef_clamped(attack_r);
                env_q  = env_saturate(longint'(env_q) + ((coef * diff) >>> CF));
                peak_q = env_q;
            end
        end
        else
        begin
            env_q = env_saturate(longint'(env_q) + ((coef_clamped(attack_r) * diff) >>> CF));
            if (env_q >= peak_q)
            begin
                peak_q = env_q;
                hold_q = hold_r;
            end
        end
        return env_q;
    endfunction

    // single sampling point: check outgoing beat, then predict incoming one
    always @(posedge clk)
    begin
        env_beat_t exp_b;
        logic [SB-1:0] pred;
        if (!rst_n)
        begin
            env_q     = '0;
            peak_q    = '0;
            hold_q    = '0;
            attack_r  = COEF_ONE[CF:0];
            release_r = COEF_ONE[CF:0];
            rlevel_r  = '0;
            hold_r    = '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                recv_count++;
                if (env_exp_q.size() == 0)
                begin
                    $error("envelope beat with no expectation waiting: envelope %0d",
                           m_tdata[SB-1:0]);
                    err_count++;
                end
                else
                begin
                    exp_b = env_exp_q.pop_front();
                    if (m_tdata[SB-1:0] !== exp_b.envelope)
                    begin
                        $error("envelope mismatch: expected %0d, actual %0d",
                               exp_b.envelope, m_tdata[SB-1:0]);
                        err_count++;
                    end
                    if (m_tlast !== exp_b.last)
                    begin
                        $error("last_out mismatch: expected %0d, actual %0d",
                               exp_b.last, m_tlast);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                pred           = track_envelope(s_tdata[SB-1:0]);
                exp_b.envelope = drv_typed ? drv_env : pred;
                exp_b.last     = s_tlast;
                env_exp_q.push_back(exp_b);
                sent_count++;
            end
            if (cfg_wen)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ATTACK_COEF:   attack_r  = cfg_wdata[CF:0];
                    REG_RELEASE_COEF:  release_r = cfg_wdata[CF:0];
                    REG_RELEASE_LEVEL: rlevel_r  = cfg_wdata[SB-1:0];
                    REG_HOLD_SAMPLES:  hold_r    = cfg_wdata[HOLD_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_sample(input logic [SB-1:0] smp, input bit last,
                               input bit typed, input logic [SB-1:0] env);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= TW'(smp);
        s_tlast   <= last;
        drv_typed <= typed;
        drv_env   <= env;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // hold off the sender until every envelope beat has drained
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (env_exp_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        wr_count++;
    endtask

    function automatic step_row_t smp_row(input logic [SB-1:0] smp, input bit last,
                                          input bit typed, input logic [SB-1:0] env);
        step_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_idx = REG_ATTACK_COEF;
        r.value   = '0;
        r.smp     = smp;
        r.last    = last;
        r.typed   = typed;
        r.env     = env;
        return r;
    endfunction

    function automatic step_row_t cfg_row(input cfg_reg_t idx, input logic [CW-1:0] val);
        step_row_t r;
        r         = smp_row('0, 1'b0, 1'b0, '0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = val;
        return r;
    endfunction

    function automatic logic [CW-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return '0;
            1:       return CW'(COEF_ONE);
            2:       return CW'($urandom_range(131071, 65537));   // above one
            3:       return CW'($urandom_range(255, 1));
            default: return CW'($urandom_range(65536, 1));
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_level();
        case ($urandom_range(4))
            0:       return '0;
            1:       return CW'(ENV_TOP);
            default: return CW'($urandom_range(8388608, 0));
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_hold();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CW'($urandom_range(1048575, 0));
            2:       return CW'(20'hFFFFF);
            default: return CW'($urandom_range(12, 1));
        endcase
    endfunction

    task automatic run_random(input int n_items, input int tx_pct, input int rx_pct);
        int done;
        int chunk;
        int seg_left;
        int amp;
        int mag;
        logic [SB-1:0] smp;
        bit last;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done        = 0;
        seg_left    = 0;
        amp         = 0;
        while (done < n_items)
        begin
            drain_results();
            write_reg(REG_ATTACK_COEF, pick_coef());
            write_reg(REG_RELEASE_COEF, pick_coef());
            write_reg(REG_RELEASE_LEVEL, pick_level());
            write_reg(REG_HOLD_SAMPLES, pick_hold());
            chunk = $urandom_range(60, 30);
            for (int k = 0; k < chunk && done < n_items; k++)
            begin
                // bursts and quiet stretches so attack, hold and release all occur
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(25, 3);
                    case ($urandom_range(7))
                        0:       amp = 0;
                        1:       amp = 8388608;
                        2:       amp = $urandom_range(255, 0);
                        default: amp = $urandom_range(8388608, 0);
                    endcase
                end
                seg_left--;
                if ($urandom_range(9) == 0)
                begin
                    smp = SB'($urandom);
                end
                else
                begin
                    mag = $urandom_range(amp, 0);
                    smp = $urandom_range(1) ? SB'(-mag) : SB'(mag);
                end
                last = ($urandom_range(15) == 0) || (seg_left == 0 && $urandom_range(1));
                send_sample(smp, last, 1'b0, '0);
                done++;
            end
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        bit prev_cfg;

        // reset settings: both coefficients 1.0, so envelope equals |sample|
        directed_q.push_back(smp_row(24'h000000, 1'b0, 1'b1, 24'd0));
        directed_q.push_back(smp_row(24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF));
        directed_q.push_back(smp_row(24'h800000, 1'b0, 1'b1, 24'h800000));
        directed_q.push_back(smp_row(24'hFFFFFF, 1'b1, 1'b1, 24'd1));
        directed_q.push_back(smp_row(24'h000000, 1'b0, 1'b1, 24'd0));
        // clamped attack, half release above a level, three-sample hold
        directed_q.push_back(cfg_row(REG_ATTACK_COEF, 24'h01FFFF));
        directed_q.push_back(cfg_row(REG_RELEASE_COEF, 24'h008000));
        directed_q.push_back(cfg_row(REG_RELEASE_LEVEL, 24'h100000));
        directed_q.push_back(cfg_row(REG_HOLD_SAMPLES, 24'd3));
        directed_q.push_back(smp_row(24'h400000, 1'b0, 1'b0, '0));
        for (int i = 0; i < 6; i++)
        begin
            directed_q.push_back(smp_row(24'h000000, (i == 5), 1'b0, '0));
        end
        // zero coefficients, top release level, longest hold
        directed_q.push_back(cfg_row(REG_ATTACK_COEF, 24'd0));
        directed_q.push_back(cfg_row(REG_RELEASE_COEF, 24'd0));
        directed_q.push_back(cfg_row(REG_RELEASE_LEVEL, 24'h800000));
        directed_q.push_back(cfg_row(REG_HOLD_SAMPLES, 24'h0FFFFF));
        directed_q.push_back(smp_row(24'h7FFFFF, 1'b0, 1'b0, '0));
        directed_q.push_back(smp_row(24'h800000, 1'b1, 1'b0, '0));
        // smallest nonzero attack with release above one
        directed_q.push_back(cfg_row(REG_ATTACK_COEF, 24'd1));
        directed_q.push_back(cfg_row(REG_RELEASE_COEF, 24'h01FFFF));
        directed_q.push_back(cfg_row(REG_HOLD_SAMPLES, 24'd0));
        directed_q.push_back(smp_row(24'h800000, 1'b0, 1'b0, '0));
        directed_q.push_back(smp_row(24'h000005, 1'b0, 1'b0, '0));
        directed_q.push_back(smp_row(24'hFFFFFB, 1'b1, 1'b0, '0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 13;
        rx_idle_pct = 59;
        prev_cfg    = 1'b0;
        foreach (directed_q[i])
        begin
            if (directed_q[i].is_cfg)
            begin
                if (!prev_cfg)
                begin
                    drain_results();
                end
                write_reg(directed_q[i].reg_idx, directed_q[i].value);
            end
            else
            begin
                send_sample(directed_q[i].smp, directed_q[i].last,
                            directed_q[i].typed, directed_q[i].env);
            end
            prev_cfg = directed_q[i].is_cfg;
        end

        run_random(150, 13, 59);
        run_random(150, 59, 13);
        run_random(150, 0, 0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (env_exp_q.size() != 0 && wait_cycles < 10000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (8) @(negedge clk);
        if (env_exp_q.size() != 0)
        begin
            $error("%0d envelope beats never arrived", env_exp_q.size());
            err_count++;
        end

        $display("Run covered %0d sample beats, %0d envelope beats, %0d register writes,",
                 sent_count, recv_count, wr_count);
        $display("across directed extremes and three sender/receiver stall mixes.");
        if (err_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
